/* rtl/fpl_pkg.sv */
// ----------------------------------------------------------------------------
// fpl_pkg: shared definitions for the four-pole resonant lowpass
// Widths, fixed-point constants, sequencer codes, channel payloads and the
// saturation helpers used by the filter datapath.
// ----------------------------------------------------------------------------
package fpl_pkg;

    // Sample and state widths
    localparam int SAMPLE_BITS = 24;
    localparam int STATE_BITS  = 32;

    // Accumulator holds a state value plus the widest scaled product
    localparam int WIDE_BITS = (STATE_BITS > SAMPLE_BITS) ? STATE_BITS : SAMPLE_BITS;
    localparam int ACC_BITS  = WIDE_BITS + 4;

    // Coefficient and configuration widths
    localparam int COEF_BITS    = 19;
    localparam int CUTOFF_BITS  = 17;
    localparam int RES_AMT_BITS = 12;
    localparam int F2_BITS      = 22;
    localparam int F4_BITS      = 28;
    localparam int OMD_BITS     = 17;

    // Shared multiplier operand widths
    localparam int MA_BITS   = (STATE_BITS > F4_BITS) ? STATE_BITS : F4_BITS;
    localparam int MB_BITS   = F2_BITS;
    localparam int PROD_BITS = MA_BITS + MB_BITS;

    // Configuration channel
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = CUTOFF_BITS;

    localparam logic [CFG_IDX_BITS-1:0] REG_CUTOFF    = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_RESONANCE = CFG_IDX_BITS'(1);

    localparam logic [CUTOFF_BITS-1:0]  CUTOFF_RESET  = CUTOFF_BITS'(11889);
    localparam logic [RES_AMT_BITS-1:0] RES_AMT_RESET = RES_AMT_BITS'(1024);

    // Fixed-point constants in Q16
    localparam logic [OMD_BITS-1:0]  Q_ONE    = OMD_BITS'(65536);
    localparam logic [MB_BITS-1:0]   K_TUNE   = MB_BITS'(76022);
    localparam logic [MB_BITS-1:0]   K_DAMP   = MB_BITS'(9830);
    localparam logic [MB_BITS-1:0]   K_GAIN   = MB_BITS'(22946);
    localparam logic [MB_BITS-1:0]   K_ZERO   = MB_BITS'(19661);
    localparam logic [MB_BITS-1:0]   K_RES    = MB_BITS'(26214);
    localparam logic [COEF_BITS-1:0] COEF_MAX = {COEF_BITS{1'b1}};

    localparam logic [PROD_BITS-1:0] RND8  = PROD_BITS'(128);
    localparam logic [PROD_BITS-1:0] RND16 = PROD_BITS'(32768);

    // Saturation limits expressed at accumulator width
    localparam logic signed [ACC_BITS-1:0] ACC_STATE_HI =
        {{(ACC_BITS-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] ACC_STATE_LO =
        {{(ACC_BITS-STATE_BITS+1){1'b1}}, {(STATE_BITS-1){1'b0}}};
    localparam logic signed [ACC_BITS-1:0] ACC_SAMPLE_HI =
        {{(ACC_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] ACC_SAMPLE_LO =
        {{(ACC_BITS-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

    // Sequencer steps
    localparam int STEP_BITS = 4;

    localparam logic [STEP_BITS-1:0] RS_FB_MUL    = STEP_BITS'(0);
    localparam logic [STEP_BITS-1:0] RS_FB_SUB    = STEP_BITS'(1);
    localparam logic [STEP_BITS-1:0] RS_GAIN_MUL  = STEP_BITS'(2);
    localparam logic [STEP_BITS-1:0] RS_GAIN_DONE = STEP_BITS'(3);
    localparam logic [STEP_BITS-1:0] RS_ADD0      = STEP_BITS'(4);
    localparam logic [STEP_BITS-1:0] RS_END0      = STEP_BITS'(5);
    localparam logic [STEP_BITS-1:0] RS_ADD1      = STEP_BITS'(6);
    localparam logic [STEP_BITS-1:0] RS_END1      = STEP_BITS'(7);
    localparam logic [STEP_BITS-1:0] RS_ADD2      = STEP_BITS'(8);
    localparam logic [STEP_BITS-1:0] RS_END2      = STEP_BITS'(9);
    localparam logic [STEP_BITS-1:0] RS_ADD3      = STEP_BITS'(10);
    localparam logic [STEP_BITS-1:0] RS_END3      = STEP_BITS'(11);

    localparam logic [STEP_BITS-1:0] DS_TUNE_MUL = STEP_BITS'(0);
    localparam logic [STEP_BITS-1:0] DS_TUNE     = STEP_BITS'(1);
    localparam logic [STEP_BITS-1:0] DS_F2_MUL   = STEP_BITS'(2);
    localparam logic [STEP_BITS-1:0] DS_F2       = STEP_BITS'(3);
    localparam logic [STEP_BITS-1:0] DS_F4_MUL   = STEP_BITS'(4);
    localparam logic [STEP_BITS-1:0] DS_F4       = STEP_BITS'(5);
    localparam logic [STEP_BITS-1:0] DS_DAMP     = STEP_BITS'(6);
    localparam logic [STEP_BITS-1:0] DS_IGAIN    = STEP_BITS'(7);
    localparam logic [STEP_BITS-1:0] DS_RES      = STEP_BITS'(8);
    localparam logic [STEP_BITS-1:0] DS_FB_MUL   = STEP_BITS'(9);
    localparam logic [STEP_BITS-1:0] DS_FB       = STEP_BITS'(10);

    typedef enum logic [1:0] {
        ST_DERIVE,
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef enum logic [3:0] {
        SA_SOP3,
        SA_X,
        SA_SIP0,
        SA_SIP1,
        SA_SOP0,
        SA_CUTOFF,
        SA_TUNE,
        SA_TMP,
        SA_RES_AMT,
        SA_RES
    } t_sel_a;

    typedef enum logic [3:0] {
        SB_FB,
        SB_GAIN,
        SB_ZERO,
        SB_OMF,
        SB_TUNE_K,
        SB_TUNE,
        SB_TMP,
        SB_DAMP_K,
        SB_GAIN_K,
        SB_RES_K,
        SB_OMD
    } t_sel_b;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_FB_SUB,
        ACT_GAIN,
        ACT_ADD,
        ACT_POLE,
        ACT_TUNE,
        ACT_TMP,
        ACT_DAMP,
        ACT_IGAIN,
        ACT_RES,
        ACT_FB
    } t_act;

    typedef struct packed {
        t_sel_a sel_a;
        t_sel_b sel_b;
        logic   sh8;
        logic   mul_en;
        t_act   act;
        logic   out_load;
    } t_ctrl;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          last_in;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          last_out;
    } t_out_item;

    function automatic logic signed [STATE_BITS-1:0] sat_state(
        input logic signed [ACC_BITS-1:0] v
    );
        if (v > ACC_STATE_HI) begin
            return ACC_STATE_HI[STATE_BITS-1:0];
        end else if (v < ACC_STATE_LO) begin
            return ACC_STATE_LO[STATE_BITS-1:0];
        end
        return v[STATE_BITS-1:0];
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [ACC_BITS-1:0] v
    );
        if (v > ACC_SAMPLE_HI) begin
            return ACC_SAMPLE_HI[SAMPLE_BITS-1:0];
        end else if (v < ACC_SAMPLE_LO) begin
            return ACC_SAMPLE_LO[SAMPLE_BITS-1:0];
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

    function automatic logic [COEF_BITS-1:0] sat_coef(input logic [PROD_BITS-1:0] v);
        if (v > PROD_BITS'(COEF_MAX)) begin
            return COEF_MAX;
        end
        return v[COEF_BITS-1:0];
    endfunction

    // Magnitude of a state value; the most negative value still fits unsigned.
    function automatic logic [MA_BITS-1:0] mag_state(input logic signed [STATE_BITS-1:0] v);
        logic [STATE_BITS:0] e;
        e = {v[STATE_BITS-1], v};
        if (v[STATE_BITS-1]) begin
            e = -e;
        end
        return MA_BITS'(e);
    endfunction

endpackage

/* rtl/fpl_in_if.sv */
// ----------------------------------------------------------------------------
// fpl_in_if: input sample channel
// Valid/ready channel carrying one audio sample and its end-of-block flag.
// ----------------------------------------------------------------------------
interface fpl_in_if import fpl_pkg::*; ();

    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

/* rtl/fpl_out_if.sv */
// ----------------------------------------------------------------------------
// fpl_out_if: filtered sample channel
// Valid/ready channel carrying one filtered sample and its end-of-block flag.
// ----------------------------------------------------------------------------
interface fpl_out_if import fpl_pkg::*; ();

    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

/* rtl/fpl_cfg_if.sv */
// ----------------------------------------------------------------------------
// fpl_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and the data to be written.
// ----------------------------------------------------------------------------
interface fpl_cfg_if import fpl_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);

endinterface

/* rtl/four_pole_resonant_lowpass.sv */
// ----------------------------------------------------------------------------
// four_pole_resonant_lowpass: ladder-style resonant lowpass, fixed point
// Samples are taken one at a time: a new sample is accepted only when idle,
// after the previous result has been loaded; ten dependent products share one
// 32x22 multiplier, stepped by the sequencer. A write to a known register,
// and reset, start the coefficient derivation on the same multiplier.
// Reset (synchronous, active low) clears the filter state, restores the reset
// cutoff and resonance and runs the derivation before the first sample.
// ----------------------------------------------------------------------------
module four_pole_resonant_lowpass import fpl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fpl_in_if.sink    i_in,
    fpl_out_if.source o_out,
    fpl_cfg_if.sink   i_cfg
);

    t_state                r_state, n_state;
    logic [STEP_BITS-1:0]  r_step, n_step;
    t_ctrl                 ctrl;

    logic [CUTOFF_BITS-1:0]  r_cutoff;
    logic [RES_AMT_BITS-1:0] r_res_amt;
    logic [COEF_BITS-1:0]    r_tune, r_fb, r_gain, r_res;
    logic [F4_BITS-1:0]      r_tmp;
    logic [OMD_BITS-1:0]     r_omd;

    logic signed [STATE_BITS-1:0] r_sip [4];
    logic signed [STATE_BITS-1:0] r_sop [4];
    logic signed [STATE_BITS-1:0] r_x;
    logic signed [ACC_BITS-1:0]   r_acc;

    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic                          r_last;

    logic [PROD_BITS-1:0] r_prod;
    logic                 r_neg;
    logic                 r_sh8;

    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_sample;
    logic                          r_out_last;

    logic in_fire, cfg_fire, cfg_known, stall;

    logic [MA_BITS-1:0]           mul_a;
    logic [MB_BITS-1:0]           mul_b;
    logic                         a_neg, b_neg;
    logic signed [STATE_BITS-1:0] a_state;
    logic                         a_is_state;
    logic signed [COEF_BITS:0]    omf;
    logic [COEF_BITS:0]           omf_mag;

    logic [PROD_BITS-1:0]       q_full;
    logic signed [ACC_BITS-1:0] q_mag, qs;
    logic signed [ACC_BITS-1:0] x_sub, y_sum;
    logic signed [STATE_BITS-1:0] y_sat;

    assign in_fire   = i_in.valid && i_in.ready;
    assign cfg_fire  = i_cfg.valid && i_cfg.ready;
    assign cfg_known = (i_cfg.index == REG_CUTOFF) || (i_cfg.index == REG_RESONANCE);
    assign stall     = r_out_valid && !o_out.ready;

    assign i_cfg.ready = (r_state == ST_IDLE);
    // A pending register write takes precedence over a new sample.
    assign i_in.ready  = (r_state == ST_IDLE) && !i_cfg.valid;

    assign o_out.valid              = r_out_valid;
    assign o_out.payload.sample_out = r_out_sample;
    assign o_out.payload.last_out   = r_out_last;

    // Next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            ST_DERIVE: begin
                if (r_step == DS_FB) begin
                    n_state = ST_IDLE;
                    n_step  = '0;
                end else begin
                    n_step = r_step + STEP_BITS'(1);
                end
            end
            ST_IDLE: begin
                n_step = '0;
                if (cfg_fire && cfg_known) begin
                    n_state = ST_DERIVE;
                end else if (in_fire) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_step == RS_END3) begin
                    if (!stall) begin
                        n_state = ST_IDLE;
                        n_step  = '0;
                    end
                end else begin
                    n_step = r_step + STEP_BITS'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_step  = '0;
            end
        endcase
    end

    // Sequencer outputs: operand selection and the action on the last product
    always_comb begin
        ctrl.sel_a    = SA_X;
        ctrl.sel_b    = SB_FB;
        ctrl.sh8      = 1'b0;
        ctrl.mul_en   = 1'b1;
        ctrl.act      = ACT_NONE;
        ctrl.out_load = 1'b0;
        case (r_state)
            ST_RUN: begin
                case (r_step)
                    RS_FB_MUL: begin
                        ctrl.sel_a = SA_SOP3;
                        ctrl.sel_b = SB_FB;
                    end
                    RS_FB_SUB: begin
                        ctrl.act = ACT_FB_SUB;
                    end
                    RS_GAIN_MUL: begin
                        ctrl.sel_a = SA_X;
                        ctrl.sel_b = SB_GAIN;
                    end
                    RS_GAIN_DONE: begin
                        ctrl.act   = ACT_GAIN;
                        ctrl.sel_a = SA_SIP0;
                        ctrl.sel_b = SB_ZERO;
                    end
                    RS_ADD0, RS_ADD1, RS_ADD2, RS_ADD3: begin
                        ctrl.act   = ACT_ADD;
                        ctrl.sel_a = SA_SOP0;
                        ctrl.sel_b = SB_OMF;
                    end
                    RS_END0, RS_END1, RS_END2: begin
                        // The stage lines have not rotated yet, so the next
                        // stage's input history sits one place up.
                        ctrl.act   = ACT_POLE;
                        ctrl.sel_a = SA_SIP1;
                        ctrl.sel_b = SB_ZERO;
                    end
                    RS_END3: begin
                        if (stall) begin
                            ctrl.mul_en = 1'b0;
                        end else begin
                            ctrl.act      = ACT_POLE;
                            ctrl.out_load = 1'b1;
                        end
                    end
                    default: begin
                        ctrl.act = ACT_NONE;
                    end
                endcase
            end
            ST_DERIVE: begin
                case (r_step)
                    DS_TUNE_MUL: begin
                        ctrl.sel_a = SA_CUTOFF;
                        ctrl.sel_b = SB_TUNE_K;
                    end
                    DS_TUNE: begin
                        ctrl.act = ACT_TUNE;
                    end
                    DS_F2_MUL: begin
                        ctrl.sel_a = SA_TUNE;
                        ctrl.sel_b = SB_TUNE;
                    end
                    DS_F2: begin
                        ctrl.act = ACT_TMP;
                    end
                    DS_F4_MUL: begin
                        ctrl.sel_a = SA_TMP;
                        ctrl.sel_b = SB_TMP;
                    end
                    DS_F4: begin
                        ctrl.act   = ACT_TMP;
                        ctrl.sel_a = SA_TMP;
                        ctrl.sel_b = SB_DAMP_K;
                    end
                    DS_DAMP: begin
                        ctrl.act   = ACT_DAMP;
                        ctrl.sel_a = SA_TMP;
                        ctrl.sel_b = SB_GAIN_K;
                    end
                    DS_IGAIN: begin
                        ctrl.act   = ACT_IGAIN;
                        ctrl.sel_a = SA_RES_AMT;
                        ctrl.sel_b = SB_RES_K;
                        ctrl.sh8   = 1'b1;
                    end
                    DS_RES: begin
                        ctrl.act = ACT_RES;
                    end
                    DS_FB_MUL: begin
                        ctrl.sel_a = SA_RES;
                        ctrl.sel_b = SB_OMD;
                    end
                    DS_FB: begin
                        ctrl.act = ACT_FB;
                    end
                    default: begin
                        ctrl.act = ACT_NONE;
                    end
                endcase
            end
            default: begin
                ctrl.act = ACT_NONE;
            end
        endcase
    end

    // Operand selection; signed operands enter the multiplier as magnitudes.
    always_comb begin
        a_state    = r_x;
        a_is_state = 1'b1;
        mul_a      = '0;
        case (ctrl.sel_a)
            SA_SOP3:    a_state = r_sop[3];
            SA_X:       a_state = r_x;
            SA_SIP0:    a_state = r_sip[0];
            SA_SIP1:    a_state = r_sip[1];
            SA_SOP0:    a_state = r_sop[0];
            SA_CUTOFF: begin
                a_is_state = 1'b0;
                mul_a      = MA_BITS'(r_cutoff);
            end
            SA_TUNE: begin
                a_is_state = 1'b0;
                mul_a      = MA_BITS'(r_tune);
            end
            SA_TMP: begin
                a_is_state = 1'b0;
                mul_a      = MA_BITS'(r_tmp);
            end
            SA_RES_AMT: begin
                a_is_state = 1'b0;
                mul_a      = MA_BITS'(r_res_amt);
            end
            SA_RES: begin
                a_is_state = 1'b0;
                mul_a      = MA_BITS'(r_res);
            end
            default: a_is_state = 1'b0;
        endcase
        a_neg = 1'b0;
        if (a_is_state) begin
            mul_a = mag_state(a_state);
            a_neg = a_state[STATE_BITS-1];
        end
    end

    assign omf     = (COEF_BITS+1)'(Q_ONE) - signed'({1'b0, r_tune});
    assign omf_mag = omf[COEF_BITS] ? (COEF_BITS+1)'(-omf) : (COEF_BITS+1)'(omf);

    always_comb begin
        b_neg = 1'b0;
        case (ctrl.sel_b)
            SB_FB:     mul_b = MB_BITS'(r_fb);
            SB_GAIN:   mul_b = MB_BITS'(r_gain);
            SB_ZERO:   mul_b = K_ZERO;
            SB_OMF: begin
                mul_b = MB_BITS'(omf_mag);
                b_neg = omf[COEF_BITS];
            end
            SB_TUNE_K: mul_b = K_TUNE;
            SB_TUNE:   mul_b = MB_BITS'(r_tune);
            SB_TMP:    mul_b = r_tmp[F2_BITS-1:0];
            SB_DAMP_K: mul_b = K_DAMP;
            SB_GAIN_K: mul_b = K_GAIN;
            SB_RES_K:  mul_b = K_RES;
            SB_OMD:    mul_b = MB_BITS'(r_omd);
            default:   mul_b = '0;
        endcase
    end

    // Rounded product, half away from zero, then the sign is restored.
    assign q_full = r_sh8 ? ((r_prod + RND8) >> 8) : ((r_prod + RND16) >> 16);
    assign q_mag  = signed'(ACC_BITS'(q_full));
    assign qs     = r_neg ? -q_mag : q_mag;

    assign x_sub = ACC_BITS'(r_sample) - qs;
    assign y_sum = r_acc + qs;
    assign y_sat = sat_state(y_sum);

    // Control state, configuration registers and filter history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_DERIVE;
            r_step      <= '0;
            r_cutoff    <= CUTOFF_RESET;
            r_res_amt   <= RES_AMT_RESET;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_sip[i] <= '0;
                r_sop[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (cfg_fire) begin
                case (i_cfg.index)
                    REG_CUTOFF:    r_cutoff  <= i_cfg.data[CUTOFF_BITS-1:0];
                    REG_RESONANCE: r_res_amt <= i_cfg.data[RES_AMT_BITS-1:0];
                    default:       r_cutoff  <= r_cutoff;
                endcase
            end
            if (ctrl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            // Each stage pushes its history to the top; after four stages the
            // lines are back in stage order.
            if (ctrl.act == ACT_POLE) begin
                for (int i = 0; i < 3; i++) begin
                    r_sip[i] <= r_sip[i+1];
                    r_sop[i] <= r_sop[i+1];
                end
                r_sip[3] <= r_x;
                r_sop[3] <= y_sat;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_sample <= i_in.payload.sample_in;
            r_last   <= i_in.payload.last_in;
        end
        if (ctrl.mul_en) begin
            r_prod <= PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
            r_neg  <= a_neg ^ b_neg;
            r_sh8  <= ctrl.sh8;
        end
        case (ctrl.act)
            ACT_FB_SUB: r_x    <= sat_state(x_sub);
            ACT_GAIN:   r_x    <= sat_state(qs);
            ACT_ADD:    r_acc  <= ACC_BITS'(r_x) + qs;
            ACT_POLE:   r_x    <= y_sat;
            ACT_TUNE:   r_tune <= sat_coef(q_full);
            ACT_TMP:    r_tmp  <= F4_BITS'(q_full);
            ACT_DAMP: begin
                if (q_full >= PROD_BITS'(Q_ONE)) begin
                    r_omd <= '0;
                end else begin
                    r_omd <= OMD_BITS'(PROD_BITS'(Q_ONE) - q_full);
                end
            end
            ACT_IGAIN:  r_gain <= sat_coef(q_full);
            ACT_RES:    r_res  <= COEF_BITS'(q_full);
            ACT_FB:     r_fb   <= sat_coef(q_full);
            default:    r_acc  <= r_acc;
        endcase
        if (ctrl.out_load) begin
            r_out_sample <= sat_sample(ACC_BITS'(y_sat));
            r_out_last   <= r_last;
        end
    end

    // A sample transaction always starts the sequencer at its first step.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == ST_RUN) && (r_step == RS_FB_MUL))
        else $error("sample accepted without starting the filter sequence");

    // A write to a known register restarts the coefficient derivation.
    a_derive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_fire && cfg_known) |=> (r_state == ST_DERIVE) && (r_step == DS_TUNE_MUL))
        else $error("register write did not start coefficient derivation");

    // A result is never written over one that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.out_load |-> (!r_out_valid || o_out.ready))
        else $error("result register overwritten while still pending");

    // A result appears only from the last stage of the sequence.
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_RUN) && ($past(r_step) == RS_END3))
        else $error("result valid raised outside the final stage");

    // The step counter stays within the sequence of its state.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_RUN) && (r_step > RS_END3)) == 1'b0
        && ((r_state == ST_DERIVE) && (r_step > DS_FB)) == 1'b0)
        else $error("sequencer step out of range");

endmodule
